// ===== hw/rtl/slc_pkg.sv =====
// Shared constants, types and codes of the cache tag and state array.
package slc_pkg;

  localparam int SETS      = 64;
  localparam int WAYS      = 4;
  localparam int ADDR_BITS = 48;
  localparam int IO_ADDR_W = 48;
  localparam int SET_W     = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int TAG_W     = ADDR_BITS;
  localparam int OFF_W     = 4;
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = 1;
  localparam int QCNT_W    = 2;

  localparam logic [OFF_W-1:0] OFF_RESET = OFF_W'(6);

  localparam logic [1:0] REQ_READ    = 2'd0;
  localparam logic [1:0] REQ_WRITE   = 2'd1;
  localparam logic [1:0] REQ_INSTALL = 2'd2;

  // One classified request as it waits for the back end.
  typedef struct packed {
    logic             dirty;
    logic [TAG_W-1:0] line;
    logic [SET_W-1:0] set;
  } req_t;

  // One set of the state memory.
  typedef struct packed {
    logic [WAYS-1:0][TAG_W-1:0] tag;
    logic [WAYS-1:0]            valid;
    logic [WAYS-1:0]            dirty;
    logic [WAYS-1:0][WAY_W-1:0] rank;
  } set_row_t;

endpackage

// ===== hw/rtl/slc_front.sv =====
// Front end: takes requests, forms line address and set, queues them.
module slc_front
  import slc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       req_type,
  input  logic [IO_ADDR_W-1:0] address,
  input  logic [OFF_W-1:0] line_offset_bits,
  output logic             q_valid,
  output req_t             q_head,
  input  logic             q_pop
);

  req_t              entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  req_t              incoming;
  logic [TAG_W-1:0]  addr_masked;

  assign in_stall = (count == QCNT_W'(QDEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != '0);
  assign q_head   = entries[rd_ptr];

  always_comb begin
    addr_masked    = TAG_W'(address);
    incoming.dirty = (req_type == REQ_WRITE) || (req_type == REQ_INSTALL);
    incoming.line  = addr_masked >> line_offset_bits;
    incoming.set   = SET_W'(incoming.line % SETS);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + QCNT_W'(push) - QCNT_W'(q_pop);
    end
  end

endmodule

// ===== hw/rtl/slc_back.sv =====
// Back end: reads a set, resolves hit or victim, writes the set back.
module slc_back
  import slc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  input  req_t                 q_head,
  output logic                 q_pop,
  input  logic [OFF_W-1:0]     line_offset_bits,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 hit,
  output logic                 victim_dirty,
  output logic [IO_ADDR_W-1:0] victim_addr
);

  typedef enum logic [1:0] {
    S_READ = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t          state;
  state_t          state_next;
  set_row_t        mem [SETS];
  set_row_t        rd_row;
  logic            rd_init;
  logic [SETS-1:0] row_init;
  req_t            cur;

  set_row_t        row;
  set_row_t        row_next;
  logic [WAYS-1:0] hit_vec;
  logic            is_hit;
  logic [WAY_W-1:0] hit_way;
  logic [WAY_W-1:0] victim;
  logic            victim_found;
  logic [WAY_W-1:0] sel;
  logic [WAY_W-1:0] old_rank;
  logic            exec_go;
  logic            ev_dirty;
  logic [TAG_W-1:0] ev_addr;

  assign q_pop   = (state == S_READ) && q_valid;
  assign exec_go = (state == S_EXEC) && (!out_valid || !out_stall);

  // A set never written since reset reads as empty with ranks in way order.
  always_comb begin
    row = rd_row;
    if (!rd_init) begin
      for (int w = 0; w < WAYS; w++) begin
        row.valid[w] = 1'b0;
        row.dirty[w] = 1'b0;
        row.rank[w]  = WAY_W'(w);
      end
    end
  end

  always_comb begin
    hit_vec      = '0;
    is_hit       = 1'b0;
    hit_way      = '0;
    victim       = '0;
    victim_found = 1'b0;
    for (int w = 0; w < WAYS; w++) begin
      hit_vec[w] = row.valid[w] && (row.tag[w] == cur.line);
    end
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (hit_vec[w]) begin
        hit_way = WAY_W'(w);
        is_hit  = 1'b1;
      end
      if (row.rank[w] == '0) begin
        victim       = WAY_W'(w);
        victim_found = 1'b1;
      end
    end
    sel      = is_hit ? hit_way : (victim_found ? victim : '0);
    old_rank = row.rank[sel];
    ev_dirty = !is_hit && row.valid[sel] && row.dirty[sel];
    ev_addr  = row.tag[sel] << line_offset_bits;

    row_next = row;
    for (int w = 0; w < WAYS; w++) begin
      if (row.rank[w] > old_rank) begin
        row_next.rank[w] = row.rank[w] - 1'b1;
      end
    end
    row_next.rank[sel] = WAY_W'(WAYS - 1);
    if (is_hit) begin
      row_next.dirty[sel] = row.dirty[sel] | cur.dirty;
    end else begin
      row_next.tag[sel]   = cur.line;
      row_next.valid[sel] = 1'b1;
      row_next.dirty[sel] = cur.dirty;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_READ: begin
        if (q_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec_go) begin
          state_next = S_READ;
        end
      end
      default: state_next = S_READ;
    endcase
  end

  // Set memory: one read port in the read step, one write port in the execute step.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      rd_row <= mem[q_head.set];
      cur    <= q_head;
    end
    if (exec_go) begin
      mem[cur.set] <= row_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_READ;
      row_init  <= '0;
      rd_init   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (q_pop) begin
        rd_init <= row_init[q_head.set];
      end
      if (exec_go) begin
        row_init[cur.set] <= 1'b1;
        out_valid         <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (exec_go) begin
      hit          <= is_hit;
      victim_dirty <= ev_dirty;
      victim_addr  <= ev_dirty ? IO_ADDR_W'(ev_addr) : '0;
    end
  end

endmodule

// ===== hw/rtl/set_assoc_lru_writeback_cache_tags.sv =====
// An accepted item is queued, its set is read in the read step, then written back with the
// result registered in the execute step; the back end takes the next item only after that write.
// The front queue holds two items, so input is taken while the back end works.
// Reset (rst, synchronous) empties the queue and output, marks every set empty
// with way k at rank k, and sets the line offset to 6; no clearing pass is needed.
module set_assoc_lru_writeback_cache_tags
  import slc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [OFF_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           req_type,
  input  logic [IO_ADDR_W-1:0] address,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 hit,
  output logic                 victim_dirty,
  output logic [IO_ADDR_W-1:0] victim_addr
);

  logic [OFF_W-1:0] line_offset_bits;
  logic             q_valid;
  req_t             q_head;
  logic             q_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_offset_bits <= OFF_RESET;
    end else if (cfg_valid && cfg_ready) begin
      line_offset_bits <= cfg_data;
    end
  end

  slc_front u_front (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .req_type         (req_type),
    .address          (address),
    .line_offset_bits (line_offset_bits),
    .q_valid          (q_valid),
    .q_head           (q_head),
    .q_pop            (q_pop)
  );

  slc_back u_back (
    .clk              (clk),
    .rst              (rst),
    .q_valid          (q_valid),
    .q_head           (q_head),
    .q_pop            (q_pop),
    .line_offset_bits (line_offset_bits),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .hit              (hit),
    .victim_dirty     (victim_dirty),
    .victim_addr      (victim_addr)
  );

endmodule

// ===== tb/set_assoc_lru_writeback_cache_tags_tb.sv =====
// Self-checking testbench of the LRU write-back cache tag array, with its own line predictor.
module set_assoc_lru_writeback_cache_tags_tb;
  import slc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] REQ_SPARE = 2'd3;
  localparam int LINES = SETS * WAYS;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [1:0]           kind;
    logic [IO_ADDR_W-1:0] addr;
  } access_t;

  typedef struct packed {
    logic                 hit;
    logic                 dirty_ev;
    logic [IO_ADDR_W-1:0] ev_addr;
  } outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [OFF_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] req_type = '0;
  logic [IO_ADDR_W-1:0] address = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic hit;
  logic victim_dirty;
  logic [IO_ADDR_W-1:0] victim_addr;

  set_assoc_lru_writeback_cache_tags u_top (.*);

  // Predicted contents of the tag array.
  logic [IO_ADDR_W-1:0] tag_mem [LINES];
  logic                 valid_mem [LINES];
  logic                 dirty_mem [LINES];
  int                   age_rank [LINES];
  logic [OFF_W-1:0]     offset_shift;

  access_t  pending_reqs[$];
  outcome_t expected_outcomes[$];
  int errors = 0;
  int hits_seen = 0;
  int dirty_evicts_seen = 0;
  int results_seen = 0;
  int cycle_count = 0;
  int long_hold = 0;
  bit sender_hold = 1'b0;
  logic [IO_ADDR_W-1:0] tag_pool [8];
  int hot_sets [4];

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic void make_recent(int base, int w);
    int prev;
    prev = age_rank[base + w];
    for (int k = 0; k < WAYS; k++) begin
      if (age_rank[base + k] > prev) age_rank[base + k]--;
    end
    age_rank[base + w] = WAYS - 1;
  endfunction

  function automatic outcome_t lookup_line(access_t a);
    outcome_t o;
    logic [IO_ADDR_W-1:0] line;
    logic wr;
    int base;
    int victim;
    o = '0;
    wr = (a.kind == REQ_WRITE) || (a.kind == REQ_INSTALL);
    line = a.addr >> offset_shift;
    base = int'(line % SETS) * WAYS;
    for (int w = 0; w < WAYS; w++) begin
      if (valid_mem[base + w] && tag_mem[base + w] == line) begin
        make_recent(base, w);
        if (wr) dirty_mem[base + w] = 1'b1;
        o.hit = 1'b1;
        return o;
      end
    end
    victim = 0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (age_rank[base + w] == 0) victim = w;
    end
    if (valid_mem[base + victim] && dirty_mem[base + victim]) begin
      o.dirty_ev = 1'b1;
      o.ev_addr = tag_mem[base + victim] << offset_shift;
    end
    tag_mem[base + victim] = line;
    valid_mem[base + victim] = 1'b1;
    dirty_mem[base + victim] = wr;
    make_recent(base, victim);
    return o;
  endfunction

  // Sender: bursts of random length separated by random gaps.
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) expected_outcomes.push_back(lookup_line({req_type, address}));
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() > 0 && !sender_hold) begin
          access_t a;
          a = pending_reqs.pop_front();
          req_type <= a.kind;
          address <= a.addr;
          in_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall pattern switches between free running, random and periodic.
  int stall_mode = 0;
  int mode_left = 0;
  int hold_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (long_hold > 0 && hold_left == 0) begin
        hold_left = long_hold;
        long_hold = 0;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          stall_mode = $urandom_range(0, 2);
          mode_left = $urandom_range(10, 80);
        end
        mode_left = mode_left - 1;
        case (stall_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 1) == 1);
          default: out_stall <= (mode_left % 4) == 0;
        endcase
      end
    end
  end

  // Result checker.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (expected_outcomes.size() == 0) begin
        $display("%0t: unexpected result hit=%0b dirty=%0b addr=%h", $time, hit,
                 victim_dirty, victim_addr);
        errors++;
      end else begin
        outcome_t e;
        e = expected_outcomes.pop_front();
        if (hit) hits_seen++;
        if (victim_dirty) dirty_evicts_seen++;
        if (hit !== e.hit) begin
          $display("%0t: hit expected %0b actual %0b", $time, e.hit, hit);
          errors++;
        end
        if (victim_dirty !== e.dirty_ev) begin
          $display("%0t: victim_dirty expected %0b actual %0b", $time, e.dirty_ev,
                   victim_dirty);
          errors++;
        end
        if (victim_addr !== e.ev_addr) begin
          $display("%0t: victim_addr expected %h actual %h", $time, e.ev_addr,
                   victim_addr);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("set_assoc_lru_writeback_cache_tags regression: fail");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || in_valid || expected_outcomes.size() > 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_offset(logic [OFF_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    offset_shift = v;
  endtask

  // Address built from a set number and a line tag under the current offset.
  function automatic logic [IO_ADDR_W-1:0] place(int set_no, logic [IO_ADDR_W-1:0] tg);
    logic [63:0] line;
    logic [63:0] low;
    line = ({16'd0, tg} << SET_W) | 64'(set_no);
    low = {$urandom, $urandom} & ((64'd1 << offset_shift) - 1);
    return IO_ADDR_W'((line << offset_shift) | low);
  endfunction

  task automatic add_random(int n);
    access_t a;
    for (int i = 0; i < n; i++) begin
      a.kind = ($urandom_range(0, 9) == 0) ? REQ_SPARE : 2'($urandom_range(0, 2));
      if ($urandom_range(0, 4) == 0) a.addr = {$urandom, $urandom};
      else a.addr = place(hot_sets[$urandom_range(0, 3)], tag_pool[$urandom_range(0, 7)]);
      pending_reqs.push_back(a);
    end
  endtask

  task automatic new_pools();
    for (int i = 0; i < 8; i++) tag_pool[i] = {$urandom, $urandom};
    for (int i = 0; i < 4; i++) hot_sets[i] = $urandom_range(0, SETS - 1);
  endtask

  initial begin
    logic [OFF_W-1:0] offsets [6];
    offsets = '{4'd2, 4'd12, 4'd0, 4'd15, 4'd6, 4'd9};
    offset_shift = OFF_RESET;
    for (int i = 0; i < LINES; i++) begin
      tag_mem[i] = '0;
      valid_mem[i] = 1'b0;
      dirty_mem[i] = 1'b0;
      age_rank[i] = i % WAYS;
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extreme addresses, every kind, then six dirty lines in one set so
    // that the two oldest are written back, followed by hits on the survivors.
    pending_reqs.push_back('{REQ_READ, 48'h0});
    pending_reqs.push_back('{REQ_WRITE, {IO_ADDR_W{1'b1}}});
    pending_reqs.push_back('{REQ_INSTALL, 48'h5555_5555_5555});
    pending_reqs.push_back('{REQ_SPARE, 48'hAAAA_AAAA_AAAA});
    pending_reqs.push_back('{REQ_READ, {IO_ADDR_W{1'b1}}});
    for (int t = 1; t <= 6; t++)
      pending_reqs.push_back('{(t % 2) ? REQ_WRITE : REQ_INSTALL, place(3, 48'(t))});
    for (int t = 3; t <= 6; t++) pending_reqs.push_back('{REQ_READ, place(3, 48'(t))});
    pending_reqs.push_back('{REQ_WRITE, place(3, 48'd1)});
    wait_drained();

    // Phases under different offsets; lines held across an offset change stay put.
    for (int p = 0; p < 6; p++) begin
      write_offset(offsets[p]);
      new_pools();
      if (p == 1) long_hold = 300;
      add_random(150);
      if (p == 2) begin
        while (pending_reqs.size() > 0) @(posedge clk);
        sender_hold = 1'b1;
        while (in_valid || expected_outcomes.size() > 0) @(posedge clk);
        sender_hold = 1'b0;
      end
      add_random(150);
      wait_drained();
    end

    repeat (20) @(posedge clk);
    $display("Covered %0d results (%0d hits, %0d dirty write-backs) across 7 offset settings.",
             results_seen, hits_seen, dirty_evicts_seen);
    if (errors == 0) begin
      $display("set_assoc_lru_writeback_cache_tags regression: pass");
    end else begin
      $display("set_assoc_lru_writeback_cache_tags regression: fail");
    end
    $finish;
  end

endmodule

// ===== set_assoc_lru_writeback_cache_tags.f =====
hw/rtl/slc_pkg.sv
hw/rtl/slc_front.sv
hw/rtl/slc_back.sv
hw/rtl/set_assoc_lru_writeback_cache_tags.sv
tb/set_assoc_lru_writeback_cache_tags_tb.sv
